FILE: rtl/waveform_hit_candidate_finder_top_macros.svh
// Assertion helpers for the hit candidate finder.
`ifndef WAVEFORM_HIT_CANDIDATE_FINDER_TOP_MACROS_SVH
`define WAVEFORM_HIT_CANDIDATE_FINDER_TOP_MACROS_SVH

// Check a condition at every edge outside reset.
`define WHCF_ASSERT_ALWAYS(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
    else $error("check failed");

// Check that an antecedent implies a consequent on the next edge.
`define WHCF_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("check failed");

`endif

FILE: rtl/whcf_pkg.sv
package whcf_pkg;

  localparam int unsigned MaxSamples = 1024;
  localparam int unsigned MaxHits    = 32;
  localparam int unsigned StackDepth = MaxHits + 1;
  localparam int unsigned MinLen     = 5;
  localparam int unsigned MinWidth   = 32;
  localparam int unsigned Recip3     = 43691;

  typedef enum logic [4:0] {
    S_LOAD, S_ACT, S_MX_RD, S_MX_CMP, S_MX_END,
    S_F_CHK, S_F_A1, S_F_A2, S_F_A3,
    S_L_INIT, S_L_CHK, S_L_A1, S_L_A2, S_L_A3,
    S_PUSH, S_POP, S_POP_W, S_FIN, S_O_RD, S_O_LD, S_O_W
  } state_e;

  typedef struct packed {
    logic [9:0]         first;
    logic [9:0]         last;
    logic [9:0]         peak;
    logic signed [15:0] height;
    logic [10:0]        hi;
  } stk_entry_t;

  typedef struct packed {
    logic [9:0]         first;
    logic [9:0]         last;
    logic [9:0]         peak;
    logic signed [15:0] height;
    logic [5:0]         grp;
  } res_entry_t;

endpackage

FILE: rtl/waveform_hit_candidate_finder_top.sv
// Hit candidate finder: samples stream in at one per cycle; the request
// flagged tlast starts a search over the stored waveform (up to 1024 samples),
// during which the input is not ready. The search runs on one sample-memory
// read port: the maximum scan reads, then compares each sample of each
// searched interval; each edge-walk step reads a sample, then both its
// neighbours. Results (up to 32) are buffered, then sent one by one, since
// the overflow flag is only final at the end of the search; an empty search
// gives one result with found low. Configuration writes are always accepted.
`include "waveform_hit_candidate_finder_top_macros.svh"

module waveform_hit_candidate_finder_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [14:0] cfg_data_i,     // roi_threshold
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // sample_value
  input  logic        s_axis_tlast,   // last_sample
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // start_index, stop_index, peak_index, peak_height, width_estimate,
  // group_index, overflow, zero fill
  output logic [71:0] m_axis_tdata,
  output logic        m_axis_tuser,   // found
  output logic        m_axis_tlast    // last_result
);

  whcf_pkg::state_e state_q, state_d;

  logic [14:0]        thr_q;
  logic [10:0]        cnt_q, cnt_d;
  logic [10:0]        lo_q, lo_d, hi_q, hi_d, i_q, i_d;
  logic [9:0]         mi_q, mi_d, f_q, f_d, l_q, l_d, prev_q, prev_d;
  logic signed [15:0] mv_q, mv_d, v_q, v_d, nb_q, nb_d;
  logic [5:0]         sp_q, sp_d, grp_q, grp_d;
  logic [6:0]         cand_q, cand_d;
  logic [4:0]         k_q, k_d;
  logic               ovf_q, ovf_d;
  logic [71:0]        tdata_q, tdata_d;
  logic               tuser_q, tuser_d, tlast_q, tlast_d;

  logic signed [15:0] smp_mem [whcf_pkg::MaxSamples];
  logic signed [15:0] smp_rdata_q;
  logic [9:0]         smp_raddr;
  logic               smp_we;

  whcf_pkg::stk_entry_t stk_mem [whcf_pkg::StackDepth];
  whcf_pkg::stk_entry_t stk_rdata_q, stk_wdata;
  logic                 stk_we;
  logic [5:0]           stk_raddr;

  whcf_pkg::res_entry_t res_mem [whcf_pkg::MaxHits];
  whcf_pkg::res_entry_t res_rdata_q, res_wdata;
  logic                 res_we;

  logic signed [16:0] thr_s, nthr_s, v_s;
  logic [10:0]        len;
  logic [9:0]         span;
  logic [29:0]        prod;
  logic [11:0]        wq, west;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == whcf_pkg::S_LOAD);
  assign m_axis_tvalid = (state_q == whcf_pkg::S_O_W);
  assign m_axis_tdata  = tdata_q;
  assign m_axis_tuser  = tuser_q;
  assign m_axis_tlast  = tlast_q;

  assign thr_s  = {2'b00, thr_q};
  assign nthr_s = -thr_s;
  assign v_s    = {smp_rdata_q[15], smp_rdata_q};
  assign len    = hi_q - lo_q;

  assign span = res_rdata_q.last - res_rdata_q.first;
  assign prod = 30'({span, 3'b000}) * 30'(whcf_pkg::Recip3);
  assign wq   = prod[28:17];
  assign west = (wq < 12'(whcf_pkg::MinWidth)) ? 12'(whcf_pkg::MinWidth) : wq;

  always_ff @(posedge clk_i) begin
    if (smp_we) begin
      smp_mem[cnt_q[9:0]] <= s_axis_tdata;
    end
    smp_rdata_q <= smp_mem[smp_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      stk_mem[sp_q] <= stk_wdata;
    end
    stk_rdata_q <= stk_mem[stk_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (res_we) begin
      res_mem[cand_q[4:0]] <= res_wdata;
    end
    res_rdata_q <= res_mem[k_q];
  end

  always_comb begin
    unique case (state_q)
      whcf_pkg::S_F_CHK: smp_raddr = f_q;
      whcf_pkg::S_F_A1:  smp_raddr = f_q + 10'd1;
      whcf_pkg::S_F_A2:  smp_raddr = f_q - 10'd1;
      whcf_pkg::S_L_CHK: smp_raddr = l_q;
      whcf_pkg::S_L_A1:  smp_raddr = l_q + 10'd1;
      whcf_pkg::S_L_A2:  smp_raddr = l_q - 10'd1;
      default:           smp_raddr = i_q[9:0];
    endcase
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      whcf_pkg::S_LOAD:
        if (s_axis_tvalid && s_axis_tlast) state_d = whcf_pkg::S_ACT;
      whcf_pkg::S_ACT:
        state_d = (len < 11'(whcf_pkg::MinLen)) ? whcf_pkg::S_POP : whcf_pkg::S_MX_RD;
      whcf_pkg::S_MX_RD:  state_d = whcf_pkg::S_MX_CMP;
      whcf_pkg::S_MX_CMP:
        state_d = (i_q + 11'd1 == hi_q) ? whcf_pkg::S_MX_END : whcf_pkg::S_MX_RD;
      whcf_pkg::S_MX_END:
        state_d = ($signed({mv_q[15], mv_q}) <= thr_s) ? whcf_pkg::S_POP
                                                       : whcf_pkg::S_F_CHK;
      whcf_pkg::S_F_CHK:
        state_d = (11'(f_q) == lo_q) ? whcf_pkg::S_L_INIT : whcf_pkg::S_F_A1;
      whcf_pkg::S_F_A1:
        state_d = (v_s < nthr_s) ? whcf_pkg::S_L_INIT : whcf_pkg::S_F_A2;
      whcf_pkg::S_F_A2:   state_d = whcf_pkg::S_F_A3;
      whcf_pkg::S_F_A3:
        state_d = (v_q < nb_q && v_q <= smp_rdata_q) ? whcf_pkg::S_L_INIT
                                                     : whcf_pkg::S_F_CHK;
      whcf_pkg::S_L_INIT: state_d = whcf_pkg::S_L_CHK;
      whcf_pkg::S_L_CHK:
        state_d = (11'(l_q) == hi_q - 11'd1) ? whcf_pkg::S_PUSH : whcf_pkg::S_L_A1;
      whcf_pkg::S_L_A1:
        state_d = (v_s < nthr_s) ? whcf_pkg::S_PUSH : whcf_pkg::S_L_A2;
      whcf_pkg::S_L_A2:   state_d = whcf_pkg::S_L_A3;
      whcf_pkg::S_L_A3:
        state_d = (v_q <= nb_q && v_q < smp_rdata_q) ? whcf_pkg::S_PUSH
                                                     : whcf_pkg::S_L_CHK;
      whcf_pkg::S_PUSH:   state_d = whcf_pkg::S_ACT;
      whcf_pkg::S_POP:
        state_d = (sp_q == 6'd0) ? whcf_pkg::S_FIN : whcf_pkg::S_POP_W;
      whcf_pkg::S_POP_W:  state_d = whcf_pkg::S_ACT;
      whcf_pkg::S_FIN:
        state_d = (cand_q == 7'd0) ? whcf_pkg::S_O_W : whcf_pkg::S_O_RD;
      whcf_pkg::S_O_RD:   state_d = whcf_pkg::S_O_LD;
      whcf_pkg::S_O_LD:   state_d = whcf_pkg::S_O_W;
      whcf_pkg::S_O_W:
        if (m_axis_tready) state_d = tlast_q ? whcf_pkg::S_LOAD : whcf_pkg::S_O_RD;
      default:            state_d = whcf_pkg::S_LOAD;
    endcase
  end

  always_comb begin
    cnt_d = cnt_q;   lo_d = lo_q;   hi_d = hi_q;   i_d = i_q;
    mi_d = mi_q;     mv_d = mv_q;   f_d = f_q;     l_d = l_q;
    v_d = v_q;       nb_d = nb_q;   sp_d = sp_q;   grp_d = grp_q;
    cand_d = cand_q; k_d = k_q;     ovf_d = ovf_q; prev_d = prev_q;
    tdata_d = tdata_q; tuser_d = tuser_q; tlast_d = tlast_q;
    smp_we = 1'b0;   stk_we = 1'b0; res_we = 1'b0;
    stk_raddr = sp_q - 6'd1;
    stk_wdata = '{first: f_q, last: l_q, peak: mi_q, height: mv_q, hi: hi_q};
    res_wdata = '{first: stk_rdata_q.first, last: stk_rdata_q.last,
                  peak: stk_rdata_q.peak, height: stk_rdata_q.height, grp: grp_q};
    unique case (state_q)
      whcf_pkg::S_LOAD:
        if (s_axis_tvalid) begin
          if (cnt_q < 11'(whcf_pkg::MaxSamples)) begin
            smp_we = 1'b1;
            cnt_d  = cnt_q + 11'd1;
          end
          if (s_axis_tlast) begin
            lo_d   = 11'd0;
            hi_d   = (cnt_q < 11'(whcf_pkg::MaxSamples)) ? cnt_q + 11'd1 : cnt_q;
            sp_d   = 6'd0;
            cand_d = 7'd0;
            grp_d  = 6'd0;
            prev_d = 10'd0;
            ovf_d  = 1'b0;
          end
        end
      whcf_pkg::S_ACT: i_d = lo_q;
      whcf_pkg::S_MX_CMP: begin
        if (i_q == lo_q || smp_rdata_q > mv_q) begin
          mv_d = smp_rdata_q;
          mi_d = i_q[9:0];
        end
        i_d = i_q + 11'd1;
      end
      whcf_pkg::S_MX_END:
        f_d = (11'(mi_q) - lo_q > 11'd2) ? mi_q - 10'd1 : lo_q[9:0];
      whcf_pkg::S_F_A1:   v_d = smp_rdata_q;
      whcf_pkg::S_F_A2:   nb_d = smp_rdata_q;
      whcf_pkg::S_F_A3:
        if (!(v_q < nb_q && v_q <= smp_rdata_q)) f_d = f_q - 10'd1;
      whcf_pkg::S_L_INIT:
        l_d = (hi_q - 11'(mi_q) > 11'd2) ? mi_q + 10'd1 : 10'(hi_q - 11'd1);
      whcf_pkg::S_L_A1:   v_d = smp_rdata_q;
      whcf_pkg::S_L_A2:   nb_d = smp_rdata_q;
      whcf_pkg::S_L_A3:
        if (!(v_q <= nb_q && v_q < smp_rdata_q)) l_d = l_q + 10'd1;
      whcf_pkg::S_PUSH:
        if (sp_q < 6'(whcf_pkg::StackDepth)) begin
          stk_we = 1'b1;
          sp_d   = sp_q + 6'd1;
          hi_d   = 11'(f_q) + 11'd1;
        end else begin
          ovf_d = 1'b1;
          lo_d  = 11'(l_q) + 11'd1;
        end
      whcf_pkg::S_POP:
        if (sp_q != 6'd0) sp_d = sp_q - 6'd1;
      whcf_pkg::S_POP_W: begin
        if (cand_q < 7'(whcf_pkg::MaxHits)) begin
          if (cand_q != 7'd0 &&
              $signed({1'b0, stk_rdata_q.first}) - $signed({1'b0, prev_q}) > 11'sd1) begin
            grp_d = grp_q + 6'd1;
            res_wdata.grp = grp_q + 6'd1;
          end
          prev_d = stk_rdata_q.last;
          res_we = 1'b1;
          cand_d = cand_q + 7'd1;
        end else begin
          ovf_d = 1'b1;
        end
        lo_d = 11'(stk_rdata_q.last) + 11'd1;
        hi_d = stk_rdata_q.hi;
      end
      whcf_pkg::S_FIN: begin
        cnt_d = 11'd0;
        k_d   = 5'd0;
        if (cand_q == 7'd0) begin
          tdata_d = {7'd0, ovf_q, 64'd0};
          tuser_d = 1'b0;
          tlast_d = 1'b1;
        end
      end
      whcf_pkg::S_O_LD: begin
        tdata_d = {7'd0, ovf_q, res_rdata_q.grp, west, res_rdata_q.height,
                   res_rdata_q.peak, res_rdata_q.last, res_rdata_q.first};
        tuser_d = 1'b1;
        tlast_d = (7'(k_q) + 7'd1 == cand_q);
      end
      whcf_pkg::S_O_W:
        if (m_axis_tready) k_d = k_q + 5'd1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= whcf_pkg::S_LOAD;
      thr_q   <= 15'd42;
      cnt_q   <= 11'd0;
      sp_q    <= 6'd0;
      cand_q  <= 7'd0;
      grp_q   <= 6'd0;
      prev_q  <= 10'd0;
      ovf_q   <= 1'b0;
      k_q     <= 5'd0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) thr_q <= cfg_data_i;
      cnt_q   <= cnt_d;
      sp_q    <= sp_d;
      cand_q  <= cand_d;
      grp_q   <= grp_d;
      prev_q  <= prev_d;
      ovf_q   <= ovf_d;
      k_q     <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q    <= lo_d;
    hi_q    <= hi_d;
    i_q     <= i_d;
    mi_q    <= mi_d;
    mv_q    <= mv_d;
    f_q     <= f_d;
    l_q     <= l_d;
    v_q     <= v_d;
    nb_q    <= nb_d;
    tdata_q <= tdata_d;
    tuser_q <= tuser_d;
    tlast_q <= tlast_d;
  end

  `WHCF_ASSERT_ALWAYS(a_stack_bound, clk_i, rst_ni, sp_q <= 6'(whcf_pkg::StackDepth))
  `WHCF_ASSERT_ALWAYS(a_cand_bound, clk_i, rst_ni, cand_q <= 7'(whcf_pkg::MaxHits))
  `WHCF_ASSERT_ALWAYS(a_no_overlap, clk_i, rst_ni, !(m_axis_tvalid && s_axis_tready))
  `WHCF_ASSERT_NEXT(a_load_after_last, clk_i, rst_ni,
                    m_axis_tvalid && m_axis_tready && m_axis_tlast,
                    s_axis_tready && cnt_q == 11'd0)

endmodule

FILE: test/tb_waveform_hit_candidate_finder_top.sv
module tb_waveform_hit_candidate_finder_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [15:0] value;
    logic        last;
  } sample_req_t;

  typedef struct {
    logic        found;
    logic [9:0]  start_idx;
    logic [9:0]  stop_idx;
    logic [9:0]  peak_idx;
    logic [15:0] height;
    logic [11:0] width;
    logic [5:0]  grp;
    logic        ovf;
    logic        last;
  } hit_t;

  localparam int IdleLimit = 300000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [14:0] cfg_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;

  waveform_hit_candidate_finder_top dut (.*);

  always #5 clk_i = ~clk_i;

  sample_req_t pending_q[$];
  hit_t        hits_q[$];
  int          wave_store[whcf_pkg::MaxSamples];
  int          wave_len = 0;
  int          roi_thr = 42;
  int          thr_plan = 42;
  int          error_cnt = 0;
  int          idle_cycles = 0;
  bit          in_fire = 1'b0;
  bit          out_fire = 1'b0;
  int          in_gap = 0;
  int          out_gap = 0;

  function automatic int draw_gap();
    return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
  endfunction

  task automatic report(input string what, input int got, input int want);
    $display("mismatch %s: got %0d, want %0d", what, got, want);
    error_cnt++;
  endtask

  function automatic void search_waveform();
    int   n, lo, hi, sp, cnt, grp, pstop, mi, mv, f, l, v, w, k;
    bit   active, ovf;
    int   st_first[whcf_pkg::StackDepth], st_last[whcf_pkg::StackDepth];
    int   st_peak[whcf_pkg::StackDepth];
    int   st_height[whcf_pkg::StackDepth], st_hi[whcf_pkg::StackDepth];
    hit_t found_q[$];
    hit_t h;
    n = wave_len;
    lo = 0;
    hi = n;
    sp = 0;
    cnt = 0;
    grp = 0;
    pstop = 0;
    active = 1'b1;
    ovf = 1'b0;
    while (1) begin
      if (active) begin
        if (hi - lo < whcf_pkg::MinLen) begin
          active = 1'b0;
          continue;
        end
        mi = lo;
        mv = wave_store[lo];
        for (int i = lo; i < hi; i++) begin
          if (wave_store[i] > mv) begin
            mv = wave_store[i];
            mi = i;
          end
        end
        if (mv <= roi_thr) begin
          active = 1'b0;
          continue;
        end
        f = (mi - lo) > 2 ? mi - 1 : lo;
        while (f != lo) begin
          v = wave_store[f];
          if (v < -roi_thr) break;
          if (v < wave_store[f+1] && v <= wave_store[f-1]) break;
          f--;
        end
        l = (hi - mi) > 2 ? mi + 1 : hi - 1;
        while (l != hi - 1) begin
          v = wave_store[l];
          if (v < -roi_thr) break;
          if (v <= wave_store[l+1] && v < wave_store[l-1]) break;
          l++;
        end
        if (sp < whcf_pkg::StackDepth) begin
          st_first[sp] = f;
          st_last[sp] = l;
          st_peak[sp] = mi;
          st_height[sp] = mv;
          st_hi[sp] = hi;
          sp++;
          hi = f + 1;
        end else begin
          ovf = 1'b1;
          lo = l + 1;
        end
      end else begin
        if (sp == 0) break;
        sp--;
        if (cnt < whcf_pkg::MaxHits) begin
          if (cnt != 0 && st_first[sp] - pstop > 1) grp = (grp + 1) & 63;
          pstop = st_last[sp];
          w = ((st_last[sp] - st_first[sp]) * 16) / 6;
          if (w < whcf_pkg::MinWidth) w = whcf_pkg::MinWidth;
          if (w > 4095) w = 4095;
          h.found = 1'b1;
          h.start_idx = st_first[sp][9:0];
          h.stop_idx = st_last[sp][9:0];
          h.peak_idx = st_peak[sp][9:0];
          h.height = st_height[sp][15:0];
          h.width = w[11:0];
          h.grp = grp[5:0];
          h.ovf = 1'b0;
          h.last = 1'b0;
          found_q.insert(found_q.size(), h);
          cnt++;
        end else begin
          ovf = 1'b1;
        end
        lo = st_last[sp] + 1;
        hi = st_hi[sp];
        active = 1'b1;
      end
    end
    wave_len = 0;
    if (found_q.size() == 0) begin
      h = '{default: '0};
      h.ovf = ovf;
      h.last = 1'b1;
      hits_q.insert(hits_q.size(), h);
    end else begin
      for (k = 0; k < found_q.size(); k++) begin
        found_q[k].ovf = ovf;
        found_q[k].last = (k == found_q.size() - 1);
        hits_q.insert(hits_q.size(), found_q[k]);
      end
    end
  endfunction

  always @(posedge clk_i) begin
    hit_t want;
    in_fire = s_axis_tvalid && s_axis_tready;
    out_fire = m_axis_tvalid && m_axis_tready;
    if (cfg_valid_i && cfg_ready_o) roi_thr = cfg_data_i;
    if (in_fire) begin
      if (wave_len < whcf_pkg::MaxSamples) begin
        wave_store[wave_len] = $signed(s_axis_tdata);
        wave_len++;
      end
      if (s_axis_tlast) search_waveform();
    end
    if (out_fire) begin
      if (hits_q.size() == 0) begin
        report("unexpected result", m_axis_tuser, 0);
      end else begin
        want = hits_q.pop_front();
        if (m_axis_tuser !== want.found) report("found", m_axis_tuser, want.found);
        if (m_axis_tdata[9:0] !== want.start_idx)
          report("start_index", m_axis_tdata[9:0], want.start_idx);
        if (m_axis_tdata[19:10] !== want.stop_idx)
          report("stop_index", m_axis_tdata[19:10], want.stop_idx);
        if (m_axis_tdata[29:20] !== want.peak_idx)
          report("peak_index", m_axis_tdata[29:20], want.peak_idx);
        if (m_axis_tdata[45:30] !== want.height)
          report("peak_height", $signed(m_axis_tdata[45:30]), $signed(want.height));
        if (m_axis_tdata[57:46] !== want.width)
          report("width_estimate", m_axis_tdata[57:46], want.width);
        if (m_axis_tdata[63:58] !== want.grp)
          report("group_index", m_axis_tdata[63:58], want.grp);
        if (m_axis_tdata[64] !== want.ovf) report("overflow", m_axis_tdata[64], want.ovf);
        if (m_axis_tlast !== want.last) report("last_result", m_axis_tlast, want.last);
      end
    end
    if (in_fire || out_fire || (cfg_valid_i && cfg_ready_o)) idle_cycles = 0;
    else if (rst_ni) idle_cycles++;
    if (idle_cycles >= IdleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    sample_req_t req;
    if (rst_ni) begin
      if (!s_axis_tvalid || in_fire) begin
        if (in_fire) in_gap = draw_gap();
        if (in_gap > 0) begin
          in_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_q.size() != 0) begin
          req = pending_q.pop_front();
          s_axis_tdata <= req.value;
          s_axis_tlast <= req.last;
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      if (out_fire) out_gap = draw_gap();
      if (out_gap > 0) begin
        out_gap--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic push_sample(input int value, input bit last);
    sample_req_t req;
    if (value > 32767) value = 32767;
    if (value < -32768) value = -32768;
    req.value = value[15:0];
    req.last = last;
    pending_q.insert(pending_q.size(), req);
  endtask

  task automatic push_list(input int vals[$]);
    foreach (vals[i]) push_sample(vals[i], i == vals.size() - 1);
  endtask

  task automatic push_noise_wave(input int len);
    for (int i = 0; i < len; i++)
      push_sample($signed(16'($urandom())), i == len - 1);
  endtask

  task automatic push_peaky_wave(input int len);
    int base, amp, pw, pos, v;
    pos = 0;
    while (pos < len) begin
      base = $urandom_range(0, thr_plan) - thr_plan / 2;
      if ($urandom_range(0, 2) == 0) begin
        amp = thr_plan + $urandom_range(1, 32767 - thr_plan / 2);
        pw = $urandom_range(1, 5);
        for (int j = -pw; j <= pw && pos < len; j++) begin
          v = amp - (amp / (pw + 1)) * (j < 0 ? -j : j);
          push_sample(v + $urandom_range(0, 3), pos == len - 1);
          pos++;
        end
      end else begin
        v = ($urandom_range(0, 9) == 0) ? -thr_plan - $urandom_range(1, 500) : base;
        if ($urandom_range(0, 4) == 0) v = $urandom_range(0, 1) ? base : v + 3;
        push_sample(v, pos == len - 1);
        pos++;
      end
    end
  endtask

  task automatic settle();
    while (pending_q.size() != 0 || s_axis_tvalid || hits_q.size() != 0)
      @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_threshold(input int value);
    @(negedge clk_i);
    cfg_data_i = value[14:0];
    cfg_valid_i = 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
    thr_plan = value;
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    push_list('{-32768});
    push_list('{0, 10, 32767, 10, 0});
    push_list('{0, 100, 200, 100});
    push_list('{-32768, 50, 43, 300, -32768, 43, 42, 32767, 5});
    push_list('{1, 90, 1, 1, 1, 80, 1, 1});
    settle();

    write_threshold(0);
    for (int i = 0; i < 4; i++) push_peaky_wave($urandom_range(1, 30));
    push_noise_wave(16);
    settle();

    write_threshold(32767);
    push_noise_wave(12);
    push_list('{32767, 32767, 32767, 32767, 32767, 32767});
    settle();

    write_threshold(300);
    for (int i = 0; i < 34; i++) begin
      push_sample(0, 1'b0);
      push_sample(500, 1'b0);
      push_sample(1000, 1'b0);
      push_sample(500, 1'b0);
      push_sample(0, 1'b0);
      push_sample(-5, i == 33);
    end
    settle();

    write_threshold($urandom_range(1, 2000));
    for (int i = 0; i < 2; i++) push_peaky_wave($urandom_range(5, 40));
    settle();

    write_threshold(42);
    push_peaky_wave($urandom_range(5, 40));
    push_noise_wave(8);
    push_sample(7, 1'b1);
    settle();

    if (error_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
